FILE: rtl/aed_pkg.sv
// shared types, constants and codes of the am envelope detector with agc
`default_nettype none

package aed_pkg;

  // sample width taken from each sample field, sign bit at the top
  localparam int SampleBits = 16;

  // field and datapath widths
  localparam int FieldBits  = 16;
  localparam int LevelBits  = 15;
  localparam int CountBits  = 4;
  localparam int PowerBits  = 2 * FieldBits;
  localparam int RootBits   = FieldBits;
  localparam int RootSteps  = RootBits;
  localparam int DivSteps   = LevelBits;

  typedef logic [FieldBits-1:0] field_t;
  typedef logic [LevelBits-1:0] level_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [PowerBits-1:0] power_t;
  typedef logic [RootBits-1:0]  root_t;

  // reset values and saturation limit
  localparam level_t LevelMax      = '1;
  localparam level_t TargetReset   = 15'd30000;
  localparam count_t IntervalReset = 4'd3;
  localparam level_t GainReset     = 15'd1;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_TARGET   = 1'b0,
    REG_INTERVAL = 1'b1
  } cfg_reg_e;

  // control sequence of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_I,
    ST_SQ_Q,
    ST_ROOT,
    ST_SCALE,
    ST_OUT,
    ST_DIV
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/am_envelope_detector_agc_core.sv
// am envelope detector with automatic gain control, top level
// a level passes the states sq_i, sq_q, root, scale and out before it is registered
// a new sample request is taken only once out has handed on the previous level;
// a packet end that updates the gain also waits in div for the bit-serial divider
// reset: asynchronous active low; peak 0, gain 1, packet count 0,
// target_level 30000, update_interval 3, output empty
`default_nettype none

module am_envelope_detector_agc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  // sample requests
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  aed_pkg::field_t i_sample_i,
  input  aed_pkg::field_t q_sample_i,
  input  logic            last_in_packet_i,
  // results
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output aed_pkg::level_t level_o,
  // configuration writes
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [0:0]      cfg_index_i,
  input  aed_pkg::level_t cfg_data_i
);
  import aed_pkg::*;

  state_e  state_q, state_d;

  level_t  target_q;
  count_t  interval_q;
  level_t  peak_q, peak_d;
  level_t  gain_q, gain_d;
  count_t  count_q, count_d;
  logic    out_valid_q, out_valid_d;
  level_t  level_q, level_d;

  field_t  abs_i_q, abs_i_d;
  field_t  abs_q_q, abs_q_d;
  logic    last_q, last_d;
  power_t  power_q, power_d;
  level_t  mag_q, mag_d;
  level_t  res_q, res_d;

  logic [SampleBits-1:0] i_low, q_low;
  logic [SampleBits-1:0] i_abs, q_abs;

  field_t  mul_a, mul_b;
  power_t  mul_p;
  power_t  radicand;
  count_t  count_inc;

  logic    root_start, root_done;
  root_t   root;
  logic    div_start, div_done;
  level_t  quotient;

  // magnitude of the low sample bits
  always_comb begin
    i_low = i_sample_i[SampleBits-1:0];
    q_low = q_sample_i[SampleBits-1:0];
    i_abs = i_low[SampleBits-1] ? (~i_low + 1'b1) : i_low;
    q_abs = q_low[SampleBits-1] ? (~q_low + 1'b1) : q_low;
  end

  // shared multiplier: i squared, q squared, then magnitude times gain
  always_comb begin
    case (state_q)
      ST_SQ_I: begin
        mul_a = abs_i_q;
        mul_b = abs_i_q;
      end
      ST_SQ_Q: begin
        mul_a = abs_q_q;
        mul_b = abs_q_q;
      end
      default: begin
        mul_a = FieldBits'(mag_q);
        mul_b = FieldBits'(gain_q);
      end
    endcase
    mul_p    = mul_a * mul_b;
    radicand = power_q + mul_p;
  end

  aed_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (radicand),
    .done_o     (root_done),
    .root_o     (root)
  );

  aed_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (target_q),
    .divisor_i  (peak_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign count_inc = count_q + 1'b1;

  // next state, datapath loads and bookkeeping
  always_comb begin
    state_d     = state_q;
    peak_d      = peak_q;
    gain_d      = gain_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    level_d     = level_q;
    abs_i_d     = abs_i_q;
    abs_q_d     = abs_q_q;
    last_d      = last_q;
    power_d     = power_q;
    mag_d       = mag_q;
    res_d       = res_q;
    root_start  = 1'b0;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          abs_i_d = FieldBits'(i_abs);
          abs_q_d = FieldBits'(q_abs);
          last_d  = last_in_packet_i;
          state_d = ST_SQ_I;
        end
      end
      ST_SQ_I: begin
        power_d = mul_p;
        state_d = ST_SQ_Q;
      end
      ST_SQ_Q: begin
        root_start = 1'b1;
        state_d    = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          mag_d = (root > RootBits'(LevelMax)) ? LevelMax : LevelBits'(root);
          if (mag_d > peak_q) begin
            peak_d = mag_d;
          end
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        res_d   = (|mul_p[PowerBits-1:LevelBits]) ? LevelMax : mul_p[LevelBits-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          level_d     = res_q;
          state_d     = ST_IDLE;
          if (last_q) begin
            count_d = count_inc;
            if (count_inc >= interval_q) begin
              count_d = '0;
              if (peak_q != '0) begin
                div_start = 1'b1;
                state_d   = ST_DIV;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          gain_d  = quotient;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      peak_q      <= '0;
      gain_q      <= GainReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      gain_q      <= gain_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TargetReset;
      interval_q <= IntervalReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TARGET:   target_q   <= cfg_data_i;
        REG_INTERVAL: interval_q <= cfg_data_i[CountBits-1:0];
        default:      ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    abs_i_q <= abs_i_d;
    abs_q_q <= abs_q_d;
    last_q  <= last_d;
    power_q <= power_d;
    mag_q   <= mag_d;
    res_q   <= res_d;
    level_q <= level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;

endmodule

`default_nettype wire

FILE: rtl/aed_isqrt.sv
// bit-serial integer square root, one root bit per cycle
`default_nettype none

module aed_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  aed_pkg::power_t radicand_i,
  output logic            done_o,
  output aed_pkg::root_t  root_o
);
  import aed_pkg::*;

  localparam int RemBits = RootBits + 1;
  localparam int CntBits = $clog2(RootSteps);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  power_t              rad_q, rad_d;
  logic [RemBits-1:0]  rem_q, rem_d;
  root_t               root_q, root_d;

  logic [RemBits+1:0]  rem_sh;
  logic [RemBits+1:0]  trial;
  logic                fits;

  // one step: bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q, rad_q[PowerBits-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // step control and datapath
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[PowerBits-3:0], 2'b00};
      rem_d  = fits ? RemBits'(rem_sh - trial) : RemBits'(rem_sh);
      root_d = {root_q[RootBits-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntBits'(RootSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: rtl/aed_div.sv
// bit-serial restoring divider for the gain update, one quotient bit per cycle
`default_nettype none

module aed_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  aed_pkg::level_t dividend_i,
  input  aed_pkg::level_t divisor_i,
  output logic            done_o,
  output aed_pkg::level_t quotient_o
);
  import aed_pkg::*;

  localparam int CntBits = $clog2(DivSteps);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  level_t              dvd_q, dvd_d;
  level_t              dvs_q, dvs_d;
  level_t              rem_q, rem_d;

  logic [LevelBits:0]  rem_sh;
  logic                fits;

  // one step: shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem_q, dvd_q[LevelBits-1]};
    fits   = (rem_sh >= {1'b0, dvs_q});
  end

  // step control; the quotient bits shift into the dividend register
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? LevelBits'(rem_sh - {1'b0, dvs_q}) : LevelBits'(rem_sh);
      dvd_d = {dvd_q[LevelBits-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench of the am envelope detector with agc
module testbench;
  import aed_pkg::*;

  localparam int SettleCycles = 48;
  localparam int LimitCycles  = 600000;
  localparam int BlockSamples = 150;
  localparam int HoldCycles   = 250;

  // envelope predictor and store of expected levels
  class level_scoreboard;
    level_t target;
    count_t interval;
    level_t peak;
    level_t gain;
    count_t packets;
    level_t expected_levels[$];
    int     checked;
    int     failures;

    function new();
      target   = TargetReset;
      interval = IntervalReset;
      peak     = '0;
      gain     = GainReset;
      packets  = '0;
      checked  = 0;
      failures = 0;
    endfunction

    function void write_register(cfg_reg_e idx, level_t data);
      case (idx)
        REG_TARGET:   target = data;
        REG_INTERVAL: interval = data[CountBits-1:0];
        default: ;
      endcase
    endfunction

    // floor of the root of i*i + q*q, found from the top bit down
    function int unsigned envelope_of(field_t i, field_t q);
      longint      si;
      longint      sq;
      longint      power;
      int unsigned root;
      int unsigned trial;
      si = $signed(i);
      sq = $signed(q);
      power = si * si + sq * sq;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        trial = root | (32'd1 << b);
        if (longint'(trial) * longint'(trial) <= power) root = trial;
      end
      return root;
    endfunction

    // accepted sample request: work out its level and the gain bookkeeping
    function void note_sample(field_t i, field_t q, logic last);
      int unsigned mag;
      int unsigned prod;
      mag = envelope_of(i, q);
      if (mag > LevelMax) mag = LevelMax;
      if (mag > peak) peak = level_t'(mag);
      prod = mag * gain;
      if (prod > LevelMax) prod = LevelMax;
      expected_levels.push_back(level_t'(prod));
      if (last) begin
        packets = packets + 1'b1;
        if (packets >= interval) begin
          // a zero peak keeps the old gain
          if (peak != '0) gain = target / peak;
          packets = '0;
        end
      end
    endfunction

    function void check_level(level_t actual);
      level_t want;
      checked++;
      if (expected_levels.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected level %0d with none pending", actual);
      end else begin
        want = expected_levels.pop_front();
        if (want !== actual) begin
          failures++;
          if (failures <= 10)
            $display("level mismatch on result %0d: expected %0d, got %0d",
                     checked, want, actual);
        end
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  field_t i_sample_i;
  field_t q_sample_i;
  logic   last_in_packet_i;
  logic   out_valid_o;
  logic   out_ready_i;
  level_t level_o;
  logic   cfg_valid_i;
  logic   cfg_ready_o;
  logic [0:0] cfg_index_i;
  level_t cfg_data_i;

  level_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cycle_count;
  int samples_sent;
  int packets_sent;
  int reg_writes;

  am_envelope_detector_agc_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .i_sample_i       (i_sample_i),
    .q_sample_i       (q_sample_i),
    .last_in_packet_i (last_in_packet_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .level_o          (level_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("timeout after %0d cycles, %0d levels pending",
               cycle_count, sb.expected_levels.size());
      $display("FAIL");
      $finish;
    end
  end

  // result side: check accepted levels, random stalls and a long hold every BlockSamples levels
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_level(level_o);
      if (sb.checked % BlockSamples == 60) hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // one sample request, with random gaps ahead of it
  task automatic send_sample(field_t i, field_t q, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    i_sample_i       <= i;
    q_sample_i       <= q;
    last_in_packet_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(i, q, last);
    samples_sent++;
    if (last) packets_sent++;
  endtask

  // write both registers back to back; the block must be idle
  task automatic program_registers(level_t target, level_t interval_word);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_TARGET;
    cfg_data_i  <= target;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(REG_TARGET, target);
    cfg_index_i <= REG_INTERVAL;
    cfg_data_i  <= interval_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(REG_INTERVAL, interval_word);
    cfg_valid_i <= 1'b0;
    reg_writes += 2;
  endtask

  // stop offering, wait for every level, then let a divider pass finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // sample of random scale, with full-scale values now and then
  function automatic field_t random_sample();
    field_t raw;
    raw = field_t'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return $signed(raw) >>> $urandom_range(0, 15);
    endcase
  endfunction

  initial begin
    int     plen;
    level_t target;
    level_t interval_word;

    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    i_sample_i       = '0;
    q_sample_i       = '0;
    last_in_packet_i = 1'b0;
    out_ready_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_TARGET;
    cfg_data_i       = '0;
    hold_left        = 0;
    cycle_count      = 0;
    samples_sent     = 0;
    packets_sent     = 0;
    reg_writes       = 0;
    send_idle_pct    = 32;
    recv_idle_pct    = 59;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero peak, large gains with saturation, full-scale samples
    program_registers(LevelMax, 15'd1);
    send_sample(16'd0, 16'd0, 1'b1);
    send_sample(16'd3, 16'd4, 1'b0);
    send_sample(-16'sd3, -16'sd4, 1'b1);
    send_sample(16'd7, 16'd0, 1'b0);
    send_sample(16'd1, 16'd0, 1'b0);
    send_sample(16'd0, 16'hffff, 1'b0);
    send_sample(16'd2, 16'd2, 1'b1);
    send_sample(16'h7fff, 16'd0, 1'b0);
    send_sample(16'h8000, 16'd0, 1'b1);
    send_sample(16'd0, 16'h7fff, 1'b0);
    // magnitude above full scale
    send_sample(16'h8000, 16'h8000, 1'b0);
    send_sample(16'h5555, 16'haaaa, 1'b1);
    send_sample(16'haaaa, 16'h5555, 1'b0);
    settle();

    // small target drives the gain to zero, zero interval updates every packet
    program_registers(15'd1, 15'h7ff0);
    send_sample(16'd100, -16'sd100, 1'b1);
    send_sample(16'd200, 16'd0, 1'b0);
    send_sample(16'hffff, 16'hffff, 1'b1);
    send_sample(16'h7fff, 16'h7fff, 1'b1);
    settle();
    program_registers(15'd30000, 15'd15);
    send_sample(16'd12, 16'd5, 1'b1);
    settle();

    // random packets in three idling phases, registers changed per block
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 32; recv_idle_pct = 59; end
        1: begin send_idle_pct = 59; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        target = ($urandom_range(0, 1) == 0) ? LevelMax
                                             : level_t'($urandom_range(1, 32767));
        // upper data bits are noise for the interval register
        interval_word = level_t'($urandom);
        interval_word[CountBits-1:0] = count_t'($urandom_range(0, 15));
        program_registers(target, interval_word);
        for (int n = 0; n < BlockSamples; n += plen) begin
          plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
                                             : $urandom_range(1, 8);
          for (int k = 0; k < plen; k++)
            send_sample(random_sample(), random_sample(), k == plen - 1);
        end
        settle();
      end
    end

    $display("checked %0d levels from %0d samples in %0d packets, %0d register writes",
             sb.checked, samples_sent, packets_sent, reg_writes);
    $display("final gain %0d, peak %0d, %0d mismatches",
             sb.gain, sb.peak, sb.failures);
    if (sb.failures == 0 && sb.expected_levels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: am_envelope_detector_agc_core.f
rtl/aed_pkg.sv
rtl/aed_isqrt.sv
rtl/aed_div.sv
rtl/am_envelope_detector_agc_core.sv
tb/sv/testbench.sv
